// ===== design/imu_moving_average_bank_assert.svh =====
`ifndef IMU_MOVING_AVERAGE_BANK_ASSERT_SVH
`define IMU_MOVING_AVERAGE_BANK_ASSERT_SVH

// condition that holds at every clock edge outside reset
`define IMB_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// consequence that holds in the same cycle as its antecedent
`define IMB_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/imb_pkg.sv =====
package imb_pkg;

  localparam int ACC_TAPS    = 10;
  localparam int GYR_TAPS    = 2;
  localparam int MAG_TAPS    = 5;
  localparam int CAL_SAMPLES = 100;
  localparam int SAMPLE_BITS = 16;

  localparam int NUM_CH      = 9;
  localparam int AVG_W       = 16;
  localparam int GYR_W       = 17;
  localparam int ACC_OFS     = 0;
  localparam int GYR_OFS     = ACC_OFS + 3 * AVG_W;
  localparam int MAG_OFS     = GYR_OFS + 3 * GYR_W;
  localparam int OUT_BITS    = MAG_OFS + 3 * AVG_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic cal_done;
    logic bias_acc;
  } imb_status_t;

endpackage

// ===== design/imb_cdiv.sv =====
module imb_cdiv #(
  parameter int IW  = 20,
  parameter int DIV = 10
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [IW-1:0] x_i,
  output logic signed [IW-1:0] q_o
);

  localparam logic [IW:0]   RECIP = (IW+1)'(((IW+1)'(1'b1) << IW) / DIV);
  localparam logic [IW-1:0] DIV_V = IW'(DIV);

  logic [IW-1:0] mag1_q, mag2_q, qe2_q, rem, qc;
  logic          neg1_q, neg2_q;
  logic [2*IW:0]   prod;
  logic [2*IW-1:0] back;
  logic signed [IW-1:0] q_q;

  // reciprocal estimate is exact or one low
  assign prod = mag1_q * RECIP;
  assign back = qe2_q * DIV_V;
  assign rem  = mag2_q - back[IW-1:0];
  assign qc   = qe2_q + IW'(rem >= DIV_V);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= x_i[IW-1];
      mag1_q <= x_i[IW-1] ? IW'(-x_i) : IW'(x_i);
      neg2_q <= neg1_q;
      mag2_q <= mag1_q;
      qe2_q  <= prod[2*IW-1:IW];
      q_q    <= neg2_q ? $signed(-qc) : $signed(qc);
    end
  end

  assign q_o = q_q;

endmodule

// ===== design/imb_lane.sv =====
module imb_lane #(
  parameter int TAPS = imb_pkg::ACC_TAPS,
  parameter int S    = imb_pkg::SAMPLE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         load_i,
  input  logic [S-1:0] sample_i,
  output logic [S-1:0] avg_o
);

  localparam int SW = S + $clog2(TAPS) + 1;

  logic [S-1:0]         ring_q [TAPS];
  logic signed [SW-1:0] sum_q, sum_d, quot;

  assign sum_d = sum_q - SW'($signed(ring_q[TAPS-1])) + SW'($signed(sample_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int i = 0; i < TAPS; i++) ring_q[i] <= '0;
    end else if (load_i) begin
      ring_q[0] <= sample_i;
      for (int i = 1; i < TAPS; i++) ring_q[i] <= ring_q[i-1];
      sum_q <= sum_d;
    end
  end

  imb_cdiv #(
    .IW  (SW),
    .DIV (TAPS)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (sum_q),
    .q_o   (quot)
  );

  assign avg_o = quot[S-1:0];

endmodule

// ===== design/imb_merge.sv =====
module imb_merge #(
  parameter int S   = imb_pkg::SAMPLE_BITS,
  parameter int CAL = imb_pkg::CAL_SAMPLES
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [imb_pkg::NUM_CH-1:0][S-1:0]     ch_i,
  output logic                                  valid_o,
  output logic [imb_pkg::OUT_TDATA_W-1:0]       data_o,
  output logic                                  bias_ready_o,
  output imb_pkg::imb_status_t                  status_o
);

  localparam int BW  = S + $clog2(CAL) + 1;
  localparam int CW  = $clog2(CAL + 1);
  localparam int EAW = (S > imb_pkg::AVG_W) ? S : imb_pkg::AVG_W;
  localparam int EGW = (S + 1 > imb_pkg::GYR_W) ? S + 1 : imb_pkg::GYR_W;

  logic [CW-1:0]        cnt_q;
  logic signed [BW-1:0] bias_q [3];
  logic signed [BW-1:0] quot   [3];
  logic                 cal_done, bias_acc;
  logic [3:0]           vld_q;
  logic [imb_pkg::NUM_CH-1:0][S-1:0] dly_q [3];
  logic [2:0]           rdy_q;
  logic [imb_pkg::OUT_TDATA_W-1:0] data_d, data_q;
  logic                 bias_ready_q;

  assign cal_done = (cnt_q == CW'(CAL));
  assign bias_acc = en_i & valid_i & ~cal_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= '0;
      for (int k = 0; k < 3; k++) bias_q[k] <= '0;
    end else begin
      if (bias_acc) begin
        cnt_q <= cnt_q + CW'(1);
        for (int k = 0; k < 3; k++) bias_q[k] <= bias_q[k] + BW'($signed(ch_i[3+k]));
      end
      if (en_i) vld_q <= {vld_q[2:0], valid_i};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_bias
    imb_cdiv #(
      .IW  (BW),
      .DIV (CAL)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (1'b1),
      .x_i   (bias_q[k]),
      .q_o   (quot[k])
    );
  end

  // gyro bias subtraction and output packing
  always_comb begin
    logic signed [EAW-1:0] av;
    logic signed [EGW-1:0] gv;
    data_d = '0;
    for (int k = 0; k < 3; k++) begin
      av = EAW'($signed(dly_q[2][k]));
      data_d[imb_pkg::ACC_OFS + k*imb_pkg::AVG_W +: imb_pkg::AVG_W] = av[imb_pkg::AVG_W-1:0];
      av = EAW'($signed(dly_q[2][6+k]));
      data_d[imb_pkg::MAG_OFS + k*imb_pkg::AVG_W +: imb_pkg::AVG_W] = av[imb_pkg::AVG_W-1:0];
      gv = EGW'($signed(dly_q[2][3+k]));
      if (rdy_q[2]) gv = gv - EGW'($signed(quot[k][S-1:0]));
      data_d[imb_pkg::GYR_OFS + k*imb_pkg::GYR_W +: imb_pkg::GYR_W] = gv[imb_pkg::GYR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0]     <= ch_i;
      dly_q[1]     <= dly_q[0];
      dly_q[2]     <= dly_q[1];
      rdy_q        <= {rdy_q[1:0], cal_done};
      data_q       <= data_d;
      bias_ready_q <= rdy_q[2];
    end
  end

  assign valid_o           = vld_q[3];
  assign data_o            = data_q;
  assign bias_ready_o      = bias_ready_q;
  assign status_o.cal_done = cal_done;
  assign status_o.bias_acc = bias_acc;

endmodule

// ===== design/imu_moving_average_bank.sv =====
// throughput: one transaction per cycle unless the output stalls; nine lanes work in
//   parallel, each with a 3-stage reciprocal-multiply divider behind its running sum
// stalls: the whole pipeline holds while the output transaction waits
// reset: asynchronous, active low; rings, sums, bias sums and calibration count clear
module imu_moving_average_bank #(
  parameter int ACC_TAPS    = imb_pkg::ACC_TAPS,
  parameter int GYR_TAPS    = imb_pkg::GYR_TAPS,
  parameter int MAG_TAPS    = imb_pkg::MAG_TAPS,
  parameter int CAL_SAMPLES = imb_pkg::CAL_SAMPLES,
  parameter int SAMPLE_BITS = imb_pkg::SAMPLE_BITS,
  localparam int IN_W       = ((imb_pkg::NUM_CH * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // acc_x, acc_y, acc_z, gyr_x, gyr_y, gyr_z, mag_x, mag_y, mag_z
  input  logic [IN_W-1:0]                 s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // acc_x_avg, acc_y_avg, acc_z_avg, gyr_x_out, gyr_y_out, gyr_z_out,
  // mag_x_avg, mag_y_avg, mag_z_avg
  output logic [imb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // bias_ready
  output logic                            m_axis_tuser
);

  logic                 en, accept;
  logic [3:0]           vld_q;
  logic [imb_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] avg;
  imb_pkg::imb_status_t status;

  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid & en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], accept};
    end
  end

  for (genvar k = 0; k < imb_pkg::NUM_CH; k++) begin : g_lane
    localparam int TAPS = (k < 3) ? ACC_TAPS : ((k < 6) ? GYR_TAPS : MAG_TAPS);
    imb_lane #(
      .TAPS (TAPS),
      .S    (SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .load_i   (accept),
      .sample_i (s_axis_tdata[k*SAMPLE_BITS +: SAMPLE_BITS]),
      .avg_o    (avg[k])
    );
  end

  imb_merge #(
    .S   (SAMPLE_BITS),
    .CAL (CAL_SAMPLES)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (vld_q[3]),
    .ch_i         (avg),
    .valid_o      (m_axis_tvalid),
    .data_o       (m_axis_tdata),
    .bias_ready_o (m_axis_tuser),
    .status_o     (status)
  );

`include "imu_moving_average_bank_assert.svh"

  `IMB_ASSERT_HOLDS(a_cal_sticky, !$fell(status.cal_done), "calibration done flag dropped")
  `IMB_ASSERT_IMPLIES(a_tuser_cal, m_axis_tvalid && m_axis_tuser, status.cal_done, "bias used before calibration finished")
  `IMB_ASSERT_IMPLIES(a_acc_cal, status.bias_acc, !m_axis_tvalid || m_axis_tready, "bias accumulated while stalled")
  `IMB_ASSERT_IMPLIES(a_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")

endmodule
